@@ design/slac_pkg.sv @@
// ----------------------------------------------------------------------------
// slac_pkg
// Shared types, sizes and helpers for the set-associative LRU eviction counter.
// ----------------------------------------------------------------------------
package slac_pkg;

    localparam int SETS     = 8;
    localparam int WAYS     = 2;
    localparam int KEY_BITS = 32;

    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W    = $clog2(WAYS + 1);
    localparam int COUNT_W  = 16;

    localparam int SETNUM_W = 3;
    localparam int ADDR_W   = 32;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SET_W-1:0]    set_t;
    typedef logic [WAY_W-1:0]    way_t;
    typedef logic [RANK_W-1:0]   rank_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // contents of one set as seen by the lookup logic
    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0][RANK_W-1:0] rank;
        logic [WAYS-1:0][KEY_BITS-1:0] key;
    } row_t;

    // what one access does to its set
    typedef struct packed {
        logic                        hit;
        logic                        evict;
        way_t                        way;
        key_t                        victim;
        logic [WAYS-1:0][RANK_W-1:0] rank;
    } upd_t;

    // fold the set number into range; narrow value, at most eight subtract steps
    function automatic set_t fold_set(logic [SETNUM_W-1:0] s);
        logic [7:0] v;
        v = 8'(s);
        for (int i = 0; i < (1 << SETNUM_W); i++)
        begin
            if (v >= 8'(SETS))
            begin
                v = v - 8'(SETS);
            end
        end
        return set_t'(v);
    endfunction

endpackage

@@ design/slac_lookup.sv @@
// ----------------------------------------------------------------------------
// slac_lookup
// Parallel tag compare, free-way search, LRU victim pick and rank update.
// ----------------------------------------------------------------------------
module slac_lookup (
    input  slac_pkg::row_t row,
    input  slac_pkg::key_t key,
    output slac_pkg::upd_t upd
);
    import slac_pkg::*;

    logic                   hit;
    way_t                   hit_way;
    logic                   free_found;
    way_t                   free_way;
    logic [AGE_W-1:0]       oldest_age;
    way_t                   oldest_way;
    way_t                   chosen;
    logic [AGE_W-1:0]       old_age;
    logic                   evict;

    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        oldest_age = '0;
        oldest_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row.valid[w])
            begin
                if (!hit && row.key[w] == key)
                begin
                    hit     = 1'b1;
                    hit_way = way_t'(w);
                end
                // ties go to the higher way
                if (AGE_W'(row.rank[w]) >= oldest_age)
                begin
                    oldest_age = AGE_W'(row.rank[w]);
                    oldest_way = way_t'(w);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_way   = way_t'(w);
            end
        end
    end

    always_comb
    begin
        evict = 1'b0;
        priority if (hit)
        begin
            chosen  = hit_way;
            old_age = AGE_W'(row.rank[hit_way]);
        end
        else if (free_found)
        begin
            chosen  = free_way;
            old_age = AGE_W'(WAYS);
        end
        else
        begin
            chosen  = oldest_way;
            old_age = AGE_W'(row.rank[oldest_way]);
            evict   = 1'b1;
        end
    end

    always_comb
    begin
        upd.hit    = hit;
        upd.evict  = evict;
        upd.way    = chosen;
        upd.victim = evict ? row.key[oldest_way] : '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (way_t'(w) == chosen)
            begin
                upd.rank[w] = '0;
            end
            else if (row.valid[w] && AGE_W'(row.rank[w]) < old_age)
            begin
                upd.rank[w] = rank_t'(row.rank[w] + 1'b1);
            end
            else
            begin
                upd.rank[w] = row.rank[w];
            end
        end
    end

endmodule

@@ design/slac_state.sv @@
// ----------------------------------------------------------------------------
// slac_state
// Key store, valid and rank flops per set, and the saturating eviction count.
// ----------------------------------------------------------------------------
module slac_state (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           flush,
    input  slac_pkg::set_t set_idx,
    input  slac_pkg::key_t key,
    input  slac_pkg::upd_t upd,
    output slac_pkg::row_t row,
    output slac_pkg::count_t count_next
);
    import slac_pkg::*;

    logic [WAYS-1:0][KEY_BITS-1:0] key_mem [SETS];
    logic [WAYS-1:0]               valid_reg [SETS];
    logic [WAYS-1:0][RANK_W-1:0]   rank_reg [SETS];
    count_t                        count_reg;

    assign row.valid = valid_reg[set_idx];
    assign row.rank  = rank_reg[set_idx];
    assign row.key   = key_mem[set_idx];

    always_comb
    begin
        count_next = count_reg;
        if (en)
        begin
            if (flush)
            begin
                count_next = '0;
            end
            else if (upd.evict && count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // keys are only read behind a valid bit, so no reset here
    always_ff @(posedge clk)
    begin
        if (en && !flush)
        begin
            key_mem[set_idx][upd.way] <= key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                rank_reg[s]  <= '0;
            end
            count_reg <= '0;
        end
        else if (en)
        begin
            count_reg <= count_next;
            if (flush)
            begin
                for (int s = 0; s < SETS; s++)
                begin
                    valid_reg[s] <= '0;
                    rank_reg[s]  <= '0;
                end
            end
            else
            begin
                valid_reg[set_idx][upd.way] <= 1'b1;
                rank_reg[set_idx]           <= upd.rank;
            end
        end
    end

endmodule

@@ design/set_assoc_lru_eviction_counter_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_eviction_counter_top
// 8-set, 2-way true-LRU cache tag model that reports and counts evictions.
// ----------------------------------------------------------------------------
// a transaction taken at an edge is loaded into the input register, then into the
// result register after one lookup/update pass, which raises the result strobe
// throughput: one transaction per cycle; busy stays low, set state is written
// at the same edge that loads the result, so the next access sees it
// reset: all entries invalid, ranks and internal eviction count zero, no strobe pending
module set_assoc_lru_eviction_counter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [slac_pkg::SETNUM_W-1:0]  set_number,
    input  logic [slac_pkg::ADDR_W-1:0]    address_key,
    output logic                           done,
    output logic                           hit,
    output logic                           evicted,
    output logic [slac_pkg::ADDR_W-1:0]    victim_key,
    output logic [slac_pkg::COUNT_W-1:0]   eviction_total
);
    import slac_pkg::*;

    logic   req_valid_reg;
    logic   mode_reg;
    set_t   set_reg;
    key_t   key_reg;

    row_t   row;
    upd_t   upd;
    count_t count_next;

    logic                done_reg;
    logic                hit_reg;
    logic                evicted_reg;
    logic [ADDR_W-1:0]   victim_reg;
    count_t              total_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            set_reg  <= fold_set(set_number);
            key_reg  <= key_t'(address_key);
        end
    end

    slac_lookup u_lookup (
        .row (row),
        .key (key_reg),
        .upd (upd)
    );

    slac_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (req_valid_reg),
        .flush      (mode_reg),
        .set_idx    (set_reg),
        .key        (key_reg),
        .upd        (upd),
        .row        (row),
        .count_next (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            hit_reg     <= !mode_reg && upd.hit;
            evicted_reg <= !mode_reg && upd.evict;
            victim_reg  <= mode_reg ? '0 : ADDR_W'(upd.victim);
            total_reg   <= count_next;
        end
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign evicted        = evicted_reg;
    assign victim_key     = victim_reg;
    assign eviction_total = total_reg;

endmodule

@@ design/slac_checker.sv @@
// ----------------------------------------------------------------------------
// slac_checker
// Port-level checks on result timing and result consistency.
// ----------------------------------------------------------------------------
module slac_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           mode,
    input  logic                           done,
    input  logic                           hit,
    input  logic                           evicted,
    input  logic [slac_pkg::ADDR_W-1:0]    victim_key,
    input  logic [slac_pkg::COUNT_W-1:0]   eviction_total
);

    // every accepted transaction produces a result strobe
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(rst_n, 2) && $past(start && !busy, 2) |-> done)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(rst_n, 2) && done |-> $past(start && !busy, 2))
        else $error("result strobe without transaction");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !evicted)
        else $error("hit and eviction together");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !evicted |-> victim_key == '0)
        else $error("victim key set without eviction");

    // a flush clears everything it reports
    a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(rst_n, 2) && $past(start && !busy && mode, 2)
            |-> !hit && !evicted && eviction_total == '0)
        else $error("flush result not cleared");

endmodule

bind set_assoc_lru_eviction_counter_top slac_checker u_slac_checker (.*);
